[design/cts_pkg.sv]
// Package for the cooperative task scheduler.
// Holds the channel word types, register and event codes, and the sequencer states.
// No dependencies.
package cts_pkg;

  localparam int NUM_TASKS_DEF = 8;
  localparam int TICK_BITS_DEF = 32;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TASKS_IN_USE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_READY_MASK = CFG_IDX_W'(1);

  localparam logic [3:0] TASKS_IN_USE_RST = 4'd8;
  localparam logic [7:0] INIT_READY_RST   = 8'hFF;

  // event kinds
  localparam logic [1:0] KIND_RETURN = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_SEM    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  return_value;
    logic        goes_waiting;
    logic        wait_on_semaphore;
    logic [31:0] wake_at;
    logic [31:0] tick_value;
    logic [7:0]  semaphore_zero_flags;
  } in_word_t;

  typedef struct packed {
    logic [2:0] selected_task;
    logic       task_valid;
    logic [7:0] ready_flags;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FIN
  } state_t;

endpackage

[design/cooperative_task_scheduler.sv]
// Cooperative task scheduler: task table, wake-time memory and a one-task-per-cycle scan.
// Depends on cts_pkg.
//
//  channel  | signals                            | direction
//  ---------+------------------------------------+-----------
//  in_      | in_valid, in_ready, in_data        | event word in
//  out_     | out_valid, out_ready, out_data     | result word out
//  cfg_     | cfg_valid, cfg_ready, cfg_index,   | register write in
//           | cfg_data                           |
//
// An event that needs no scan goes from accept through ST_FIN to the output register. A
// scan (ST_PREP, ST_SCAN, ST_FIN) visits n tasks at most, n the active task count:
// one task per cycle, set by the single wake-time memory read port and its compare.
// Reset (rst_n low, synchronous) marks the first eight tasks ready, clears all wake
// and wait state and the tick. in_ready is low while a word is in work; a result
// held by a stalled output does not block the next accept until its own result.
module cooperative_task_scheduler #(
  parameter int NUM_TASKS = cts_pkg::NUM_TASKS_DEF,
  parameter int TICK_BITS = cts_pkg::TICK_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  cts_pkg::in_word_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output cts_pkg::out_word_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [cts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cts_pkg::*;

  localparam int TIDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W  = $clog2(NUM_TASKS + 1);
  localparam int CMP_W  = (CNT_W > 4) ? CNT_W : 4;

  state_t                 state_r, state_nxt;
  logic                   pending_r, pending_nxt;
  logic [TIDX_W-1:0]      running_r, running_nxt;
  logic [TIDX_W-1:0]      scan_start_r, scan_start_nxt;
  logic [NUM_TASKS-1:0]   ready_r, ready_nxt;
  logic [NUM_TASKS-1:0]   semw_r, semw_nxt;
  logic [NUM_TASKS-1:0]   wake_vld_r, wake_vld_nxt;
  logic [TICK_BITS-1:0]   tick_r, tick_nxt;
  logic [3:0]             tasks_r, tasks_nxt;
  logic [TIDX_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]       left_r, left_nxt;
  logic [7:0]             sem_r, sem_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_data_r, out_data_nxt;

  // wake-time memory; an entry counts only while its valid bit is set
  logic [TICK_BITS-1:0]   wake_mem [NUM_TASKS];
  logic [TICK_BITS-1:0]   mem_rd_r;
  logic                   mem_we;
  logic [TIDX_W-1:0]      mem_wa;
  logic [TIDX_W-1:0]      mem_ra;

  logic [CMP_W-1:0]       n_cmp;
  logic [CMP_W-1:0]       tasks_ext;
  logic [CMP_W-1:0]       start_ext;
  logic [CMP_W-1:0]       idx_inc;
  logic [TIDX_W-1:0]      scan_first;
  logic [TIDX_W-1:0]      idx_wrap;
  logic [63:0]            wake_ext;
  logic [63:0]            tick_ext;
  logic [63:0]            sem_ext;
  logic [63:0]            ready_ext;
  logic [63:0]            run_ext;
  logic [TICK_BITS-1:0]   wake_in;
  logic [NUM_TASKS-1:0]   sem_vec;
  logic                   sem_hit;
  logic                   wake_hit;
  logic                   found;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wake_ext = 64'(in_data.wake_at);
  assign tick_ext = 64'(in_data.tick_value);
  assign wake_in  = wake_ext[TICK_BITS-1:0];
  assign sem_ext  = 64'(sem_r);
  assign ready_ext = 64'(ready_r);
  assign run_ext  = 64'(running_r);

  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      sem_vec[i] = sem_ext[i];
    end
  end

  // clamp the task count to 1..NUM_TASKS
  assign tasks_ext = CMP_W'(tasks_r);
  always_comb begin
    if (tasks_ext == '0) begin
      n_cmp = CMP_W'(1);
    end else if (tasks_ext > CMP_W'(NUM_TASKS)) begin
      n_cmp = CMP_W'(NUM_TASKS);
    end else begin
      n_cmp = tasks_ext;
    end
  end

  assign start_ext  = (in_data.return_value == 4'd0) ? '0
                    : CMP_W'(in_data.return_value) - CMP_W'(1);
  assign scan_first = (CMP_W'(scan_start_r) < n_cmp) ? scan_start_r : '0;
  assign idx_inc    = CMP_W'(idx_r) + CMP_W'(1);
  assign idx_wrap   = (idx_inc < n_cmp) ? TIDX_W'(idx_inc) : '0;

  assign sem_hit  = !ready_r[idx_r] && semw_r[idx_r] && sem_vec[idx_r];
  assign wake_hit = !ready_r[idx_r] && wake_vld_r[idx_r] && (mem_rd_r <= tick_r);
  assign found    = ready_r[idx_r] || sem_hit || wake_hit;

  always_comb begin
    state_nxt      = state_r;
    pending_nxt    = pending_r;
    running_nxt    = running_r;
    scan_start_nxt = scan_start_r;
    ready_nxt      = ready_r;
    semw_nxt       = semw_r;
    wake_vld_nxt   = wake_vld_r;
    tick_nxt       = tick_r;
    tasks_nxt      = tasks_r;
    idx_nxt        = idx_r;
    left_nxt       = left_r;
    sem_nxt        = sem_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = running_r;
    mem_ra         = idx_r;
    in_ready       = (state_r == ST_IDLE);

    // a write to the initial ready mask is ignored; reset always loads INIT_READY_RST
    if (cfg_valid && cfg_index == CFG_TASKS_IN_USE) begin
      tasks_nxt = cfg_data[3:0];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sem_nxt = in_data.semaphore_zero_flags;
          case (in_data.kind)
            KIND_RETURN: begin
              if (!pending_r) begin
                if (in_data.goes_waiting) begin
                  ready_nxt[running_r]    = 1'b0;
                  semw_nxt[running_r]     = in_data.wait_on_semaphore;
                  wake_vld_nxt[running_r] = (wake_in != '0);
                  mem_we                  = 1'b1;
                end else begin
                  ready_nxt[running_r]    = 1'b1;
                  semw_nxt[running_r]     = 1'b0;
                  wake_vld_nxt[running_r] = 1'b0;
                end
                scan_start_nxt = (start_ext < n_cmp) ? TIDX_W'(start_ext) : '0;
              end
              state_nxt = ST_PREP;
            end
            KIND_TICK: begin
              tick_nxt  = tick_ext[TICK_BITS-1:0];
              state_nxt = pending_r ? ST_PREP : ST_FIN;
            end
            KIND_SEM: begin
              state_nxt = pending_r ? ST_PREP : ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_PREP: begin
        // fetch the first wake time of the scan
        mem_ra    = scan_first;
        idx_nxt   = scan_first;
        left_nxt  = CNT_W'(n_cmp - CMP_W'(1));
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        mem_ra = idx_wrap;
        if (found) begin
          ready_nxt[idx_r] = 1'b1;
          if (wake_hit) begin
            wake_vld_nxt[idx_r] = 1'b0;
          end
          running_nxt = idx_r;
          pending_nxt = 1'b0;
          state_nxt   = ST_FIN;
        end else if (left_r == '0) begin
          pending_nxt = 1'b1;
          state_nxt   = ST_FIN;
        end else begin
          idx_nxt  = idx_wrap;
          left_nxt = left_r - CNT_W'(1);
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.selected_task = pending_r ? 3'd0 : run_ext[2:0];
          out_data_nxt.task_valid    = !pending_r;
          out_data_nxt.ready_flags   = ready_ext[7:0];
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wake_mem[mem_wa] <= wake_in;
    end
    mem_rd_r <= wake_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pending_r    <= 1'b0;
      running_r    <= '0;
      scan_start_r <= '0;
      ready_r      <= NUM_TASKS'(64'(INIT_READY_RST));
      semw_r       <= '0;
      wake_vld_r   <= '0;
      tick_r       <= '0;
      tasks_r      <= TASKS_IN_USE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pending_r    <= pending_nxt;
      running_r    <= running_nxt;
      scan_start_r <= scan_start_nxt;
      ready_r      <= ready_nxt;
      semw_r       <= semw_nxt;
      wake_vld_r   <= wake_vld_nxt;
      tick_r       <= tick_nxt;
      tasks_r      <= tasks_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    left_r     <= left_nxt;
    sem_r      <= sem_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for cooperative_task_scheduler: event words with random
// gaps and output stalls, checked against a scheduler model kept inside the bench or a directed table.
// Depends on cts_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb;
  import cts_pkg::*;

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_DIRECTED = 22;
  localparam int NUM_PHASES = 5;
  localparam logic [3:0] PH_TASKS [NUM_PHASES] = '{4'd15, 4'd0, 4'd3, 4'd8, 4'd6};
  localparam logic [7:0] PH_MASK [NUM_PHASES] = '{8'h00, 8'hA5, 8'hFF, 8'h5A, 8'h00};
  localparam int PH_ITEMS [NUM_PHASES] = '{250, 120, 200, 250, 180};

  typedef struct {
    in_word_t  ev;
    bit        has_want;
    out_word_t want;
  } directed_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // expectation typed into the directed table, carried alongside in_data
  bit fixed_valid = 1'b0;
  out_word_t fixed_word = '0;

  // scheduler model state; a write to the initial ready mask is ignored, reset loads INIT_READY_RST
  logic [3:0] mdl_tasks_reg = TASKS_IN_USE_RST;
  logic [7:0] mdl_ready = INIT_READY_RST;
  logic [7:0] mdl_semwait = '0;
  logic [31:0] mdl_wake [8] = '{default: '0};
  logic [31:0] mdl_tick = '0;
  logic [2:0] mdl_running = '0;
  logic [2:0] mdl_start = '0;
  logic mdl_pending = 1'b0;

  out_word_t due_picks [$];
  directed_row_t rows [NUM_DIRECTED];

  int errors = 0;
  int events_taken = 0;
  int picks_checked = 0;
  int idle_picks = 0;
  int idle_cycles = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  cooperative_task_scheduler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_count();
    if (mdl_tasks_reg == 0) return 1;
    if (mdl_tasks_reg > 8) return 8;
    return int'(mdl_tasks_reg);
  endfunction

  // one cyclic pass from the held start; wake waiters as they are visited
  function automatic bit scan_for_ready(input logic [7:0] sem);
    int n, idx, i;
    n = active_count();
    idx = (mdl_start < n) ? int'(mdl_start) : 0;
    for (i = 0; i < n; i++) begin
      if (!mdl_ready[idx]) begin
        if (mdl_semwait[idx] && sem[idx]) mdl_ready[idx] = 1'b1;
        if (mdl_wake[idx] != 0 && mdl_wake[idx] <= mdl_tick) begin
          mdl_ready[idx] = 1'b1;
          mdl_wake[idx] = '0;
        end
      end
      if (mdl_ready[idx]) begin
        mdl_running = idx[2:0];
        return 1'b1;
      end
      idx = (idx + 1 >= n) ? 0 : idx + 1;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t schedule_event(input in_word_t w);
    bit scan_now;
    int n, start;
    out_word_t pick;
    scan_now = 1'b0;
    case (w.kind)
      KIND_RETURN: begin
        if (!mdl_pending) begin
          n = active_count();
          start = (w.return_value == 0) ? 0 : int'(w.return_value) - 1;
          if (w.goes_waiting) begin
            mdl_ready[mdl_running] = 1'b0;
            mdl_semwait[mdl_running] = w.wait_on_semaphore;
            mdl_wake[mdl_running] = w.wake_at;
          end else begin
            mdl_ready[mdl_running] = 1'b1;
            mdl_semwait[mdl_running] = 1'b0;
            mdl_wake[mdl_running] = '0;
          end
          mdl_start = (start < n) ? start[2:0] : 3'd0;
        end
        scan_now = 1'b1;
      end
      KIND_TICK: begin
        mdl_tick = w.tick_value;
        scan_now = mdl_pending;
      end
      KIND_SEM: scan_now = mdl_pending;
      default: ;
    endcase
    if (scan_now) mdl_pending = !scan_for_ready(w.semaphore_zero_flags);
    pick.selected_task = mdl_pending ? 3'd0 : mdl_running;
    pick.task_valid = !mdl_pending;
    pick.ready_flags = mdl_ready;
    return pick;
  endfunction

  function automatic in_word_t make_event(input logic [1:0] kind, input logic [3:0] rv,
                                          input logic waits, input logic on_sem,
                                          input logic [31:0] wake, input logic [31:0] tick,
                                          input logic [7:0] sem);
    in_word_t w;
    w.kind = kind;
    w.return_value = rv;
    w.goes_waiting = waits;
    w.wait_on_semaphore = on_sem;
    w.wake_at = wake;
    w.tick_value = tick;
    w.semaphore_zero_flags = sem;
    return w;
  endfunction

  function automatic in_word_t random_event(input bit allow_stuck);
    in_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    w.kind = (pick < 55) ? KIND_RETURN : (pick < 75) ? KIND_TICK :
             (pick < 95) ? KIND_SEM : KIND_RESERVED;
    w.return_value = 4'($urandom_range(0, 15));
    w.goes_waiting = 1'($urandom_range(0, 1));
    w.wait_on_semaphore = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: w.wake_at = '0;
      1: w.wake_at = $urandom_range(1, 64);
      2: w.wake_at = $urandom();
      default: w.wake_at = '1;
    endcase
    case ($urandom_range(0, 3))
      0: w.tick_value = $urandom();
      1: w.tick_value = '1;
      default: w.tick_value = $urandom_range(0, 80);
    endcase
    w.semaphore_zero_flags = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'h00;
    // a wait with neither semaphore nor timer never ends; keep it rare
    if (w.goes_waiting && !w.wait_on_semaphore && w.wake_at == 0 &&
        !(allow_stuck && $urandom_range(0, 9) == 0))
      w.wake_at = 32'd1;
    return w;
  endfunction

  task automatic send_event(input in_word_t w, input bit has_want, input out_word_t want);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    fixed_valid <= has_want;
    fixed_word <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_picks.size() != 0);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  always @(posedge clk) begin
    out_word_t want, pred;
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_TASKS_IN_USE) mdl_tasks_reg = cfg_data[3:0];
    end
    if (rst_n && out_valid && out_ready) begin
      picks_checked++;
      if (due_picks.size() == 0) begin
        $error("result word %h with no expectation waiting", out_data);
        errors++;
      end else begin
        want = due_picks.pop_front();
        if (!want.task_valid) idle_picks++;
        if (out_data.selected_task !== want.selected_task) begin
          $error("selected_task: expected %0d, got %0d", want.selected_task,
                 out_data.selected_task);
          errors++;
        end
        if (out_data.task_valid !== want.task_valid) begin
          $error("task_valid: expected %0d, got %0d", want.task_valid, out_data.task_valid);
          errors++;
        end
        if (out_data.ready_flags !== want.ready_flags) begin
          $error("ready_flags: expected %h, got %h", want.ready_flags, out_data.ready_flags);
          errors++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      events_taken++;
      pred = schedule_event(in_data);
      due_picks.push_back(fixed_valid ? fixed_word : pred);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin : receiver
    int stall, taken;
    taken = 0;
    forever begin
      if (taken % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid && out_ready));
      taken++;
    end
  end

  initial begin : stimulus
    int i, ph, k;
    // after reset all eight tasks are ready and task 0 counts as running
    rows[0]  = '{make_event(KIND_TICK, 4'd0, 1'b0, 1'b0, 32'd0, 32'd0, 8'h00),
                 1'b1, '{3'd0, 1'b1, 8'hFF}};
    rows[1]  = '{make_event(KIND_RESERVED, 4'd15, 1'b1, 1'b1, '1, '1, 8'hFF),
                 1'b1, '{3'd0, 1'b1, 8'hFF}};
    rows[2]  = '{make_event(KIND_SEM, 4'd0, 1'b0, 1'b0, 32'd0, 32'd0, 8'hFF),
                 1'b1, '{3'd0, 1'b1, 8'hFF}};
    rows[3]  = '{make_event(KIND_RETURN, 4'd0, 1'b0, 1'b0, 32'd0, 32'd0, 8'h00),
                 1'b1, '{3'd0, 1'b1, 8'hFF}};
    // start past the table wraps to task 0, which now waits
    rows[4]  = '{make_event(KIND_RETURN, 4'd15, 1'b1, 1'b1, 32'd0, 32'd0, 8'h00),
                 1'b1, '{3'd1, 1'b1, 8'hFE}};
    rows[5]  = '{make_event(KIND_RETURN, 4'd8, 1'b1, 1'b0, '1, 32'd0, 8'h00),
                 1'b1, '{3'd7, 1'b1, 8'hFC}};
    // park the remaining tasks until nothing is ready
    rows[6]  = '{make_event(KIND_RETURN, 4'd1, 1'b1, 1'b0, 32'd5, 32'd0, 8'h00), 1'b0, '0};
    rows[7]  = '{make_event(KIND_RETURN, 4'd4, 1'b1, 1'b1, 32'd3, 32'd0, 8'h00), 1'b0, '0};
    rows[8]  = '{make_event(KIND_RETURN, 4'd0, 1'b1, 1'b1, 32'd0, 32'd0, 8'h00), 1'b0, '0};
    rows[9]  = '{make_event(KIND_RETURN, 4'd6, 1'b1, 1'b0, 32'd200, 32'd0, 8'h00), 1'b0, '0};
    rows[10] = '{make_event(KIND_RETURN, 4'd7, 1'b1, 1'b1, 32'd100, 32'd0, 8'h00), 1'b0, '0};
    rows[11] = '{make_event(KIND_RETURN, 4'd9, 1'b1, 1'b0, 32'd100, 32'd0, 8'h00), 1'b0, '0};
    // return with no task running is dropped and only rescans
    rows[12] = '{make_event(KIND_RETURN, 4'd5, 1'b0, 1'b0, 32'd0, 32'd0, 8'h00), 1'b0, '0};
    rows[13] = '{make_event(KIND_TICK, 4'd0, 1'b0, 1'b0, 32'd0, 32'd3, 8'h00), 1'b0, '0};
    rows[14] = '{make_event(KIND_TICK, 4'd0, 1'b0, 1'b0, 32'd0, 32'd1000, 8'h00), 1'b0, '0};
    rows[15] = '{make_event(KIND_RETURN, 4'd0, 1'b1, 1'b1, 32'd0, 32'd0, 8'h08), 1'b0, '0};
    rows[16] = '{make_event(KIND_RETURN, 4'd2, 1'b1, 1'b1, '1, 32'd0, 8'h00), 1'b0, '0};
    rows[17] = '{make_event(KIND_SEM, 4'd0, 1'b0, 1'b0, 32'd0, 32'd0, 8'hFF), 1'b0, '0};
    rows[18] = '{make_event(KIND_RETURN, 4'd15, 1'b0, 1'b0, 32'd0, 32'd0, 8'hFF), 1'b0, '0};
    rows[19] = '{make_event(KIND_TICK, 4'd0, 1'b0, 1'b0, 32'd0, '1, 8'h00), 1'b0, '0};
    rows[20] = '{make_event(KIND_RETURN, 4'd3, 1'b1, 1'b0, 32'd1, 32'd0, 8'h00), 1'b0, '0};
    rows[21] = '{make_event(KIND_RETURN, 4'd0, 1'b0, 1'b1, '1, 32'd0, 8'h55), 1'b0, '0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) send_event(rows[i].ev, rows[i].has_want, rows[i].want);
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(CFG_TASKS_IN_USE, CFG_DATA_W'(PH_TASKS[ph]));
      write_reg(CFG_INIT_READY_MASK, PH_MASK[ph]);
      cfg_valid <= 1'b0;
      for (k = 0; k < PH_ITEMS[ph]; k++) begin
        if (k % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        // hold off now and then until every pick is back
        if (k > 0 && k % 64 == 0) wait_drained();
        send_event(random_event(ph == NUM_PHASES - 1), 1'b0, '0);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("%0d event words sent over %0d register settings, %0d picks checked",
             events_taken, NUM_PHASES + 1, picks_checked);
    $display("%0d picks reported no task ready", idle_picks);
    if (errors == 0 && due_picks.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
